[design/cpp_pkg.sv]
// ----------------------------------------------------------------------------
// Camera point projection package
// Shared widths, codes, beat types and fixed-point helpers for the projection
// pipeline.
// ----------------------------------------------------------------------------
package cpp_pkg;

   // Fixed-point formats.
   localparam int NORM_FRAC       = 24;
   localparam int PIXEL_FRAC_BITS = 8;
   localparam int COEF_FRAC       = 15;
   localparam int COEF_SHIFT      = NORM_FRAC - COEF_FRAC;
   localparam int FIELD_SHIFT     = NORM_FRAC + PIXEL_FRAC_BITS;

   // Field widths.
   localparam int COORD_W  = 32;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int ROT_W    = 20;
   localparam int PROD_W   = ROT_W + DIFF_W;
   localparam int CAM_W    = PROD_W + 2;
   localparam int COEF_W   = 20;
   localparam int KSC_W    = COEF_W + COEF_SHIFT;
   localparam int PIX_W    = 20;
   localparam int SIZE_W   = 12;
   localparam int NORM_W   = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;

   // Divider: 7 integer and 24 fraction quotient bits.
   localparam int DIV_STEPS = NORM_W - 1;
   localparam int DIV_SAT_SHIFT = 7;
   localparam int DIV_R_W   = CAM_W + DIV_SAT_SHIFT;

   // Distortion pipeline depth.
   localparam int DST_STAGES = 8;

   localparam logic signed [NORM_W-1:0] NORM_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [NORM_W-1:0] NORM_ONE = 32'sh0100_0000;

   // Status codes.
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BEHIND = 2'd1;
   localparam logic [1:0] ST_FIELD  = 2'd2;
   localparam logic [1:0] ST_IMAGE  = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_ROT_ROW_0  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_ROW_1  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_ROW_2  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_XY  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Z   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RADIAL     = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TANG_SIZE  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_INTRINSICS = 4'd7;

   // Decoded camera configuration.
   typedef struct packed {
      logic [2:0][2:0][ROT_W-1:0] rot;
      logic [COORD_W-1:0]         center_x;
      logic [COORD_W-1:0]         center_y;
      logic [COORD_W-1:0]         center_z;
      logic [KSC_W-1:0]           k1;
      logic [KSC_W-1:0]           k2;
      logic [KSC_W-1:0]           k3;
      logic [KSC_W-1:0]           p1;
      logic [KSC_W-1:0]           p2;
      logic [SIZE_W-1:0]          img_w;
      logic [SIZE_W-1:0]          img_h;
      logic [PIX_W-1:0]           focal;
      logic [PIX_W-1:0]           prin_x;
      logic [PIX_W-1:0]           prin_y;
   } cam_cfg_type;

   typedef struct packed {
      logic signed [CAM_W-1:0] cam_x;
      logic signed [CAM_W-1:0] cam_y;
      logic signed [CAM_W-1:0] cam_z;
   } cam_beat_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] x;
      logic signed [NORM_W-1:0] y;
      logic                     behind;
   } norm_beat_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_u;
      logic [PIX_W-1:0] pixel_v;
      logic [1:0]       status;
   } pix_beat_type;

   // Saturate to +-(2^31-1).
   function automatic logic signed [NORM_W-1:0] sat31(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return NORM_MAX;
      end else if (v < -64'sd2147483647) begin
         return -NORM_MAX;
      end
      return v[NORM_W-1:0];
   endfunction

   // Finish a Q7.24 product: floor to 24 fraction bits, then saturate.
   function automatic logic signed [NORM_W-1:0] qfin(input logic signed [63:0] p);
      return sat31(p >>> NORM_FRAC);
   endfunction

endpackage

[design/cpp_req_if.sv]
// ----------------------------------------------------------------------------
// Point request channel
// Valid/ready channel carrying one world point per beat.
// ----------------------------------------------------------------------------
interface cpp_req_if
   import cpp_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic signed [COORD_W-1:0] point_z;

   modport source (output valid, point_x, point_y, point_z, input ready);
   modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

[design/cpp_rsp_if.sv]
// ----------------------------------------------------------------------------
// Pixel response channel
// Valid/ready channel carrying one projected pixel and its status per beat.
// ----------------------------------------------------------------------------
interface cpp_rsp_if
   import cpp_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_u;
   logic [PIX_W-1:0] pixel_v;
   logic [1:0]       status;

   modport source (output valid, pixel_u, pixel_v, status, input ready);
   modport sink   (input valid, pixel_u, pixel_v, status, output ready);
endinterface

[design/cpp_csr_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
interface cpp_csr_if
   import cpp_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/cpp_xform.sv]
// ----------------------------------------------------------------------------
// Camera transform
// Subtracts the camera center and rotates into camera axes in three stages.
// ----------------------------------------------------------------------------
module cpp_xform
   import cpp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  logic signed [COORD_W-1:0] point_x,
   input  logic signed [COORD_W-1:0] point_y,
   input  logic signed [COORD_W-1:0] point_z,
   input  cam_cfg_type               cfg,
   output logic                      out_valid,
   output cam_beat_type              out_beat
);

   logic [2:0] vld_ff;
   logic signed [DIFF_W-1:0] diff_ff [3];
   logic signed [DIFF_W-1:0] diff_in [3];
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [PROD_W-1:0] prod_in [3][3];
   cam_beat_type cam_ff;
   cam_beat_type cam_in;

   // Stage one: offset from the camera center.
   always_comb begin
      diff_in[0] = DIFF_W'(point_x) - DIFF_W'(signed'(cfg.center_x));
      diff_in[1] = DIFF_W'(point_y) - DIFF_W'(signed'(cfg.center_y));
      diff_in[2] = DIFF_W'(point_z) - DIFF_W'(signed'(cfg.center_z));
   end

   // Stage two: the nine rotation products.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = PROD_W'(signed'(cfg.rot[i][j])) * PROD_W'(diff_ff[j]);
         end
      end
   end

   // Stage three: row sums.
   always_comb begin
      cam_in.cam_x = CAM_W'(prod_ff[0][0]) + CAM_W'(prod_ff[0][1]) + CAM_W'(prod_ff[0][2]);
      cam_in.cam_y = CAM_W'(prod_ff[1][0]) + CAM_W'(prod_ff[1][1]) + CAM_W'(prod_ff[1][2]);
      cam_in.cam_z = CAM_W'(prod_ff[2][0]) + CAM_W'(prod_ff[2][1]) + CAM_W'(prod_ff[2][2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         diff_ff <= diff_in;
         prod_ff <= prod_in;
         cam_ff  <= cam_in;
      end
   end

   assign out_valid = vld_ff[2];
   assign out_beat  = cam_ff;

endmodule

[design/cpp_divide.sv]
// ----------------------------------------------------------------------------
// Depth divider
// Pipelined restoring division of x and y by depth, one quotient bit per
// stage, with saturation and sign restore.
// ----------------------------------------------------------------------------
module cpp_divide
   import cpp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  cam_beat_type  in_beat,
   output logic          out_valid,
   output norm_beat_type out_beat
);

   typedef struct packed {
      logic [DIV_R_W-1:0]   r_x;
      logic [DIV_R_W-1:0]   r_y;
      logic [DIV_R_W-1:0]   den;
      logic [DIV_STEPS-1:0] q_x;
      logic [DIV_STEPS-1:0] q_y;
      logic                 neg_x;
      logic                 neg_y;
      logic                 sat_x;
      logic                 sat_y;
      logic                 behind;
   } div_stage_type;

   div_stage_type st_ff [DIV_STEPS+1];
   div_stage_type st_in [DIV_STEPS+1];
   logic [DIV_STEPS:0] vld_ff;
   logic               out_vld_ff;
   norm_beat_type      out_ff;
   norm_beat_type      out_in;

   // One restoring step for one coordinate.
   function automatic void div_bit(input logic [DIV_R_W-1:0] r, input logic [DIV_R_W-1:0] den,
                                   input logic [DIV_STEPS-1:0] q,
                                   output logic [DIV_R_W-1:0] r_next,
                                   output logic [DIV_STEPS-1:0] q_next);
      logic [DIV_R_W-1:0] r2;
      r2 = {r[DIV_R_W-2:0], 1'b0};
      if (r2 >= den) begin
         r_next = r2 - den;
         q_next = {q[DIV_STEPS-2:0], 1'b1};
      end else begin
         r_next = r2;
         q_next = {q[DIV_STEPS-2:0], 1'b0};
      end
   endfunction

   // Stage zero takes magnitudes and scales the divisor by the saturation limit,
   // so every following step keeps an unsaturated remainder below the divisor.
   always_comb begin
      logic [CAM_W-1:0] mag_x;
      logic [CAM_W-1:0] mag_y;
      mag_x = in_beat.cam_x[CAM_W-1] ? CAM_W'(-in_beat.cam_x) : in_beat.cam_x;
      mag_y = in_beat.cam_y[CAM_W-1] ? CAM_W'(-in_beat.cam_y) : in_beat.cam_y;
      st_in[0].den    = {{DIV_SAT_SHIFT{1'b0}}, in_beat.cam_z} << DIV_SAT_SHIFT;
      st_in[0].r_x    = {{DIV_SAT_SHIFT{1'b0}}, mag_x};
      st_in[0].r_y    = {{DIV_SAT_SHIFT{1'b0}}, mag_y};
      st_in[0].q_x    = '0;
      st_in[0].q_y    = '0;
      st_in[0].neg_x  = in_beat.cam_x[CAM_W-1];
      st_in[0].neg_y  = in_beat.cam_y[CAM_W-1];
      st_in[0].sat_x  = st_in[0].r_x >= st_in[0].den;
      st_in[0].sat_y  = st_in[0].r_y >= st_in[0].den;
      st_in[0].behind = in_beat.cam_z[CAM_W-1] || (in_beat.cam_z == '0);
      for (int k = 1; k <= DIV_STEPS; k++) begin
         st_in[k] = st_ff[k-1];
         div_bit(st_ff[k-1].r_x, st_ff[k-1].den, st_ff[k-1].q_x, st_in[k].r_x, st_in[k].q_x);
         div_bit(st_ff[k-1].r_y, st_ff[k-1].den, st_ff[k-1].q_y, st_in[k].r_y, st_in[k].q_y);
      end
   end

   // Final stage: saturate and restore the sign.
   always_comb begin
      logic [DIV_STEPS-1:0] res_x;
      logic [DIV_STEPS-1:0] res_y;
      res_x = st_ff[DIV_STEPS].sat_x ? NORM_MAX[DIV_STEPS-1:0] : st_ff[DIV_STEPS].q_x;
      res_y = st_ff[DIV_STEPS].sat_y ? NORM_MAX[DIV_STEPS-1:0] : st_ff[DIV_STEPS].q_y;
      out_in.x = st_ff[DIV_STEPS].neg_x ? -signed'({1'b0, res_x}) : signed'({1'b0, res_x});
      out_in.y = st_ff[DIV_STEPS].neg_y ? -signed'({1'b0, res_y}) : signed'({1'b0, res_y});
      out_in.behind = st_ff[DIV_STEPS].behind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[DIV_STEPS-1:0], in_valid};
         out_vld_ff <= vld_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff  <= st_in;
         out_ff <= out_in;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_beat  = out_ff;

endmodule

[design/cpp_distort.sv]
// ----------------------------------------------------------------------------
// Lens distortion and pixel mapping
// Field check, Brown-Conrady distortion, focal scaling and image check in an
// eight-stage pipeline; the last stage is the response register.
// ----------------------------------------------------------------------------
module cpp_distort
   import cpp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  norm_beat_type in_beat,
   input  cam_cfg_type   cfg,
   output logic          out_valid,
   output pix_beat_type  out_beat
);

   localparam int FX_W  = NORM_W - 1 + PIX_W;
   localparam int PU_W  = NORM_W + PIX_W + 1;
   localparam int SUM_W = NORM_W + 3;
   localparam int UV_W  = PU_W - NORM_FRAC + 1;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [NORM_W-1:0] x;
      logic signed [NORM_W-1:0] y;
      logic [FX_W-1:0]          fx;
      logic [FX_W-1:0]          fy;
      logic signed [63:0]       pxx;
      logic signed [63:0]       pyy;
      logic signed [63:0]       pxy;
      logic signed [NORM_W-1:0] x2;
      logic signed [NORM_W-1:0] y2;
      logic signed [NORM_W-1:0] xy;
      logic signed [NORM_W-1:0] r2;
      logic signed [NORM_W-1:0] tx;
      logic signed [NORM_W-1:0] ty;
      logic signed [63:0]       pk3;
      logic signed [63:0]       pa;
      logic signed [63:0]       pb;
      logic signed [63:0]       pc;
      logic signed [63:0]       pd;
      logic signed [63:0]       pt1;
      logic signed [63:0]       pt2;
      logic signed [63:0]       pcx;
      logic signed [63:0]       pcy;
      logic signed [PU_W-1:0]   pu;
      logic signed [PU_W-1:0]   pv;
      logic [PIX_W-1:0]         pixel_u;
      logic [PIX_W-1:0]         pixel_v;
   } dst_stage_type;

   dst_stage_type st_ff [DST_STAGES];
   dst_stage_type st_in [DST_STAGES];
   logic [DST_STAGES-1:0] vld_ff;

   always_comb begin
      logic [NORM_W-1:0]        ax;
      logic [NORM_W-1:0]        ay;
      logic [FX_W:0]            wlim;
      logic [FX_W:0]            hlim;
      logic signed [NORM_W-1:0] t1;
      logic signed [NORM_W-1:0] t2;
      logic signed [NORM_W-1:0] c;
      logic signed [SUM_W-1:0]  sx;
      logic signed [SUM_W-1:0]  sy;
      logic signed [NORM_W-1:0] xd;
      logic signed [NORM_W-1:0] yd;
      logic signed [UV_W-1:0]   u;
      logic signed [UV_W-1:0]   v;
      logic signed [UV_W-1:0]   ulim;
      logic signed [UV_W-1:0]   vlim;

      // Stage one: squares, cross term and field-limit products.
      ax = in_beat.x[NORM_W-1] ? NORM_W'(-in_beat.x) : in_beat.x;
      ay = in_beat.y[NORM_W-1] ? NORM_W'(-in_beat.y) : in_beat.y;
      st_in[0]        = '0;
      st_in[0].status = in_beat.behind ? ST_BEHIND : ST_OK;
      st_in[0].x      = in_beat.x;
      st_in[0].y      = in_beat.y;
      st_in[0].fx     = FX_W'(ax[NORM_W-2:0]) * FX_W'(cfg.focal);
      st_in[0].fy     = FX_W'(ay[NORM_W-2:0]) * FX_W'(cfg.focal);
      st_in[0].pxx    = 64'(in_beat.x) * 64'(in_beat.x);
      st_in[0].pyy    = 64'(in_beat.y) * 64'(in_beat.y);
      st_in[0].pxy    = 64'(in_beat.x) * 64'(in_beat.y);

      // Stage two: radius squared and field-limit check.
      wlim = (FX_W+1)'(cfg.img_w) << FIELD_SHIFT;
      hlim = (FX_W+1)'(cfg.img_h) << FIELD_SHIFT;
      st_in[1]    = st_ff[0];
      st_in[1].x2 = qfin(st_ff[0].pxx);
      st_in[1].y2 = qfin(st_ff[0].pyy);
      st_in[1].xy = qfin(st_ff[0].pxy);
      st_in[1].r2 = sat31(64'(st_in[1].x2) + 64'(st_in[1].y2));
      if (st_ff[0].status == ST_OK &&
          !({1'b0, st_ff[0].fx} < wlim && {1'b0, st_ff[0].fy} < hlim)) begin
         st_in[1].status = ST_FIELD;
      end

      // Stage three: tangential arguments and first coefficient products.
      st_in[2]     = st_ff[1];
      st_in[2].tx  = sat31(64'(st_ff[1].r2) + (64'(st_ff[1].x2) <<< 1));
      st_in[2].ty  = sat31(64'(st_ff[1].r2) + (64'(st_ff[1].y2) <<< 1));
      st_in[2].pk3 = 64'(st_ff[1].r2) * 64'(signed'(cfg.k3));
      st_in[2].pa  = 64'(signed'(cfg.p2)) * 64'(st_ff[1].xy);
      st_in[2].pb  = 64'(signed'(cfg.p1)) * 64'(st_ff[1].xy);

      // Stage four: inner radial term and the tangential square products.
      t1 = sat31(64'(signed'(cfg.k2)) + 64'(qfin(st_ff[2].pk3)));
      st_in[3]     = st_ff[2];
      st_in[3].pt1 = 64'(st_ff[2].r2) * 64'(t1);
      st_in[3].pc  = 64'(signed'(cfg.p1)) * 64'(st_ff[2].tx);
      st_in[3].pd  = 64'(signed'(cfg.p2)) * 64'(st_ff[2].ty);

      // Stage five: middle radial term.
      t2 = sat31(64'(signed'(cfg.k1)) + 64'(qfin(st_ff[3].pt1)));
      st_in[4]     = st_ff[3];
      st_in[4].pt2 = 64'(st_ff[3].r2) * 64'(t2);

      // Stage six: radial gain applied to the normalized point.
      c = sat31(64'(NORM_ONE) + 64'(qfin(st_ff[4].pt2)));
      st_in[5]     = st_ff[4];
      st_in[5].pcx = 64'(c) * 64'(st_ff[4].x);
      st_in[5].pcy = 64'(c) * 64'(st_ff[4].y);

      // Stage seven: distorted point scaled by the focal length.
      sx = SUM_W'(qfin(st_ff[5].pcx)) + (SUM_W'(qfin(st_ff[5].pa)) <<< 1)
         + SUM_W'(qfin(st_ff[5].pc));
      sy = SUM_W'(qfin(st_ff[5].pcy)) + (SUM_W'(qfin(st_ff[5].pb)) <<< 1)
         + SUM_W'(qfin(st_ff[5].pd));
      xd = sat31(64'(sx));
      yd = sat31(64'(sy));
      st_in[6]    = st_ff[5];
      st_in[6].pu = PU_W'(signed'({1'b0, cfg.focal})) * PU_W'(xd);
      st_in[6].pv = PU_W'(signed'({1'b0, cfg.focal})) * PU_W'(yd);

      // Stage eight: principal point and image bounds.
      u = UV_W'(st_ff[6].pu >>> NORM_FRAC) + UV_W'(signed'({1'b0, cfg.prin_x}));
      v = UV_W'(st_ff[6].pv >>> NORM_FRAC) + UV_W'(signed'({1'b0, cfg.prin_y}));
      ulim = UV_W'(signed'({1'b0, cfg.img_w}) - 13'sd1) <<< PIXEL_FRAC_BITS;
      vlim = UV_W'(signed'({1'b0, cfg.img_h}) - 13'sd1) <<< PIXEL_FRAC_BITS;
      st_in[7] = st_ff[6];
      if (st_ff[6].status == ST_OK &&
          !(!u[UV_W-1] && u < ulim && !v[UV_W-1] && v < vlim)) begin
         st_in[7].status = ST_IMAGE;
      end
      st_in[7].pixel_u = (st_in[7].status == ST_OK) ? u[PIX_W-1:0] : '0;
      st_in[7].pixel_v = (st_in[7].status == ST_OK) ? v[PIX_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DST_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   assign out_valid        = vld_ff[DST_STAGES-1];
   assign out_beat.pixel_u = st_ff[DST_STAGES-1].pixel_u;
   assign out_beat.pixel_v = st_ff[DST_STAGES-1].pixel_v;
   assign out_beat.status  = st_ff[DST_STAGES-1].status;

endmodule

[design/camera_point_projection_top.sv]
// ----------------------------------------------------------------------------
// Camera point projection
// Projects world points through a pinhole camera with lens distortion.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one world point (Q16.16 x, y, z) per beat. rsp_chan
//   returns one beat per point, in order: pixel u and v in Q12.8 and a status
//   (ok, behind camera, outside field limits, outside image). Rejected points
//   give a zero pixel.
//   csr_chan writes the camera registers by index; it is always ready and
//   must be used only while no point is in flight.
// Pipeline and throughput:
//   A point passes from accept to response through the transform, the depth
//   divider (one quotient bit per stage over 31 bits), and distortion and pixel
//   mapping. One point is accepted every cycle unless the response is held.
// Reset:
//   Synchronous reset clears all pipeline valid bits and the camera registers.
// Stall:
//   When the response is held by the receiver the whole pipeline freezes and
//   req_chan.ready drops; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module camera_point_projection_top
   import cpp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   cpp_req_if.sink   req_chan,
   cpp_rsp_if.source rsp_chan,
   cpp_csr_if.sink   csr_chan
);

   logic [59:0] rot0_ff;
   logic [59:0] rot1_ff;
   logic [59:0] rot2_ff;
   logic [63:0] center_xy_ff;
   logic [31:0] center_z_ff;
   logic [59:0] radial_ff;
   logic [63:0] tang_size_ff;
   logic [59:0] intr_ff;

   cam_cfg_type   cfg;
   logic          adv;
   logic          xf_valid;
   cam_beat_type  xf_beat;
   logic          dv_valid;
   norm_beat_type dv_beat;
   logic          ds_valid;
   pix_beat_type  ds_beat;

   // Configuration registers.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot0_ff      <= '0;
         rot1_ff      <= '0;
         rot2_ff      <= '0;
         center_xy_ff <= '0;
         center_z_ff  <= '0;
         radial_ff    <= '0;
         tang_size_ff <= '0;
         intr_ff      <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_ROT_ROW_0:  rot0_ff      <= csr_chan.data[59:0];
            REG_ROT_ROW_1:  rot1_ff      <= csr_chan.data[59:0];
            REG_ROT_ROW_2:  rot2_ff      <= csr_chan.data[59:0];
            REG_CENTER_XY:  center_xy_ff <= csr_chan.data;
            REG_CENTER_Z:   center_z_ff  <= csr_chan.data[31:0];
            REG_RADIAL:     radial_ff    <= csr_chan.data[59:0];
            REG_TANG_SIZE:  tang_size_ff <= csr_chan.data;
            REG_INTRINSICS: intr_ff      <= csr_chan.data[59:0];
            default: ;
         endcase
      end
   end

   // Field decode; coefficients are widened to 24 fraction bits.
   always_comb begin
      cfg.rot[0] = rot0_ff;
      cfg.rot[1] = rot1_ff;
      cfg.rot[2] = rot2_ff;
      cfg.center_x = center_xy_ff[31:0];
      cfg.center_y = center_xy_ff[63:32];
      cfg.center_z = center_z_ff;
      cfg.k1 = {radial_ff[19:0], {COEF_SHIFT{1'b0}}};
      cfg.k2 = {radial_ff[39:20], {COEF_SHIFT{1'b0}}};
      cfg.k3 = {radial_ff[59:40], {COEF_SHIFT{1'b0}}};
      cfg.p1 = {tang_size_ff[19:0], {COEF_SHIFT{1'b0}}};
      cfg.p2 = {tang_size_ff[39:20], {COEF_SHIFT{1'b0}}};
      cfg.img_w  = tang_size_ff[51:40];
      cfg.img_h  = tang_size_ff[63:52];
      cfg.focal  = intr_ff[19:0];
      cfg.prin_x = intr_ff[39:20];
      cfg.prin_y = intr_ff[59:40];
   end

   // The pipeline advances unless a finished beat is held at the output.
   assign adv            = !ds_valid || rsp_chan.ready;
   assign req_chan.ready = adv;

   cpp_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_chan.valid),
      .point_x   (req_chan.point_x),
      .point_y   (req_chan.point_y),
      .point_z   (req_chan.point_z),
      .cfg       (cfg),
      .out_valid (xf_valid),
      .out_beat  (xf_beat)
   );

   cpp_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (xf_valid),
      .in_beat   (xf_beat),
      .out_valid (dv_valid),
      .out_beat  (dv_beat)
   );

   cpp_distort u_distort (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (dv_valid),
      .in_beat   (dv_beat),
      .cfg       (cfg),
      .out_valid (ds_valid),
      .out_beat  (ds_beat)
   );

   assign rsp_chan.valid   = ds_valid;
   assign rsp_chan.pixel_u = ds_beat.pixel_u;
   assign rsp_chan.pixel_v = ds_beat.pixel_v;
   assign rsp_chan.status  = ds_beat.status;

   // A rejected point always carries a zero pixel.
   a_reject_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != ST_OK) |->
      (rsp_chan.pixel_u == '0 && rsp_chan.pixel_v == '0))
      else $error("rejected point with nonzero pixel");

   // An accepted pixel lies inside the image.
   a_ok_inside : assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == ST_OK) |->
      (32'(rsp_chan.pixel_u) < ((32'(cfg.img_w) - 32'd1) << PIXEL_FRAC_BITS) &&
       32'(rsp_chan.pixel_v) < ((32'(cfg.img_h) - 32'd1) << PIXEL_FRAC_BITS)))
      else $error("accepted pixel outside image");

   // Reset empties the pipeline.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid right after reset");

endmodule

[verif/camera_point_projection_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera point projection testbench
// Drives world points through the projection block with random gaps on both
// channels, predicts every pixel and status in fixed point, and compares each
// response beat field by field. Camera registers are rewritten between phases
// while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;
   import cpp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cpp_req_if req_chan ();
   cpp_rsp_if rsp_chan ();
   cpp_csr_if csr_chan ();

   camera_point_projection_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #10 clock = ~clock;

   localparam int PIPE_CYCLES = 44;

   typedef struct {
      logic [19:0] u;
      logic [19:0] v;
      logic [1:0]  st;
   } pixel_type;

   // Model copy of the camera registers.
   logic [63:0] cam_reg [8];

   pixel_type pending_pixels [$];
   int     error_count = 0;
   int     beats_in = 0;
   int     beats_out = 0;
   int     status_seen [4] = '{0, 0, 0, 0};
   bit     hold_rsp = 1'b0;
   bit     stimulus_done = 1'b0;

   // Directed rows: point and, where obvious, the status it must give.
   typedef struct {
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      bit          typed;
      logic [1:0]  st;
   } point_row_type;

   function automatic longint sfield(logic [63:0] v, int pos, int w);
      logic [63:0] m;
      longint      r;
      m = (64'd1 << w) - 64'd1;
      r = longint'((v >> pos) & m);
      if (r[w-1]) begin
         r = r - (longint'(1) << w);
      end
      return r;
   endfunction

   function automatic longint ufield(logic [63:0] v, int pos, int w);
      return longint'((v >> pos) & ((64'd1 << w) - 64'd1));
   endfunction

   function automatic longint clamp31(longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end else if (v < -64'sd2147483647) begin
         return -64'sd2147483647;
      end
      return v;
   endfunction

   function automatic longint mul_q24(longint a, longint b);
      return clamp31((a * b) >>> 24);
   endfunction

   // Depth divide to Q7.24, truncated toward zero and saturated.
   function automatic longint depth_divide(longint num, longint den);
      logic [63:0] a;
      logic [63:0] q;
      logic [63:0] rem;
      longint      r;
      a = (num < 0) ? -num : num;
      q = a / den;
      rem = a % den;
      if (q >= 128) begin
         r = 64'sd2147483647;
      end else begin
         for (int i = 0; i < 24; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
               rem = rem - den;
               q[0] = 1'b1;
            end
         end
         r = longint'(q);
      end
      return (num < 0) ? -r : r;
   endfunction

   function automatic pixel_type project_point(logic [31:0] px, logic [31:0] py,
                                               logic [31:0] pz);
      pixel_type   res;
      longint      d [3];
      longint      cam [3];
      longint      x, y, ax, ay, f, w, h, k1, k2, k3, p1, p2;
      longint      x2, y2, xy, r2, t, c, xd, yd, u, v;
      logic [63:0] rowv;
      res.u = '0;
      res.v = '0;
      d[0] = sfield(px, 0, 32) - sfield(cam_reg[REG_CENTER_XY], 0, 32);
      d[1] = sfield(py, 0, 32) - sfield(cam_reg[REG_CENTER_XY], 32, 32);
      d[2] = sfield(pz, 0, 32) - sfield(cam_reg[REG_CENTER_Z], 0, 32);
      for (int i = 0; i < 3; i++) begin
         rowv = cam_reg[i];
         cam[i] = 0;
         for (int j = 0; j < 3; j++) begin
            cam[i] += sfield(rowv, 20 * j, 20) * d[j];
         end
      end
      if (cam[2] <= 0) begin
         res.st = ST_BEHIND;
         return res;
      end
      x = depth_divide(cam[0], cam[2]);
      y = depth_divide(cam[1], cam[2]);
      f = ufield(cam_reg[REG_INTRINSICS], 0, 20);
      w = ufield(cam_reg[REG_TANG_SIZE], 40, 12);
      h = ufield(cam_reg[REG_TANG_SIZE], 52, 12);
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      if (!(ax * f < (w << 32) && ay * f < (h << 32))) begin
         res.st = ST_FIELD;
         return res;
      end
      k1 = sfield(cam_reg[REG_RADIAL], 0, 20) * 512;
      k2 = sfield(cam_reg[REG_RADIAL], 20, 20) * 512;
      k3 = sfield(cam_reg[REG_RADIAL], 40, 20) * 512;
      p1 = sfield(cam_reg[REG_TANG_SIZE], 0, 20) * 512;
      p2 = sfield(cam_reg[REG_TANG_SIZE], 20, 20) * 512;
      x2 = mul_q24(x, x);
      y2 = mul_q24(y, y);
      xy = mul_q24(x, y);
      r2 = clamp31(x2 + y2);
      t = clamp31(k2 + mul_q24(r2, k3));
      t = clamp31(k1 + mul_q24(r2, t));
      c = clamp31((longint'(1) << 24) + mul_q24(r2, t));
      xd = clamp31(mul_q24(c, x) + 2 * mul_q24(p2, xy)
                   + mul_q24(p1, clamp31(r2 + 2 * x2)));
      yd = clamp31(mul_q24(c, y) + 2 * mul_q24(p1, xy)
                   + mul_q24(p2, clamp31(r2 + 2 * y2)));
      u = ((f * xd) >>> 24) + ufield(cam_reg[REG_INTRINSICS], 20, 20);
      v = ((f * yd) >>> 24) + ufield(cam_reg[REG_INTRINSICS], 40, 20);
      if (!(u >= 0 && u < ((w - 1) << 8) && v >= 0 && v < ((h - 1) << 8))) begin
         res.st = ST_IMAGE;
         return res;
      end
      res.u = u[19:0];
      res.v = v[19:0];
      res.st = ST_OK;
      return res;
   endfunction

   // Q2.17 rotation entry helpers.
   function automatic logic [63:0] pack3(logic [19:0] a, logic [19:0] b,
                                         logic [19:0] c);
      return {4'd0, c, b, a};
   endfunction

   task automatic write_reg(logic [3:0] idx, logic [63:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      case (idx)
         REG_CENTER_XY, REG_TANG_SIZE: cam_reg[idx[2:0]] = val;
         REG_CENTER_Z: cam_reg[idx[2:0]] = {32'd0, val[31:0]};
         default: cam_reg[idx[2:0]] = {4'd0, val[59:0]};
      endcase
      @(posedge clock);
   endtask

   // Wait until the pipeline has drained.
   task automatic drain_pipeline();
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_CYCLES + 4) @(posedge clock);
   endtask

   task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.point_x <= px;
      req_chan.point_y <= py;
      req_chan.point_z <= pz;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic stop_sending();
      req_chan.valid <= 1'b0;
   endtask

   // Camera setup: identity-like rotation with random perturbation, or all random if extreme.
   task automatic load_camera(bit extreme, bit distort);
      logic [19:0] one_q;
      logic [63:0] tv;
      one_q = 20'd131072;
      if (extreme) begin
         write_reg(REG_ROT_ROW_0, {$urandom, $urandom});
         write_reg(REG_ROT_ROW_1, {$urandom, $urandom});
         write_reg(REG_ROT_ROW_2, {$urandom, $urandom});
         write_reg(REG_CENTER_XY, {$urandom, $urandom});
         write_reg(REG_CENTER_Z, {$urandom, $urandom});
         write_reg(REG_RADIAL, {$urandom, $urandom});
         write_reg(REG_TANG_SIZE, {$urandom, $urandom});
         write_reg(REG_INTRINSICS, {$urandom, $urandom});
      end else begin
         write_reg(REG_ROT_ROW_0, pack3(one_q - 20'($urandom_range(0, 2000)),
                                        20'($urandom_range(0, 4000) - 2000), 20'd0));
         write_reg(REG_ROT_ROW_1, pack3(20'($urandom_range(0, 4000) - 2000),
                                        one_q - 20'($urandom_range(0, 2000)), 20'd0));
         write_reg(REG_ROT_ROW_2, pack3(20'd0, 20'($urandom_range(0, 200) - 100),
                                        one_q));
         write_reg(REG_CENTER_XY, {32'($urandom_range(0, 200000) - 100000),
                                   32'($urandom_range(0, 200000) - 100000)});
         write_reg(REG_CENTER_Z, 64'(32'($urandom_range(0, 100000) - 50000)));
         if (distort) begin
            write_reg(REG_RADIAL, pack3(20'($urandom_range(0, 20000) - 10000),
                                        20'($urandom_range(0, 8000) - 4000),
                                        20'($urandom_range(0, 2000) - 1000)));
            tv = {12'($urandom_range(320, 4095)), 12'($urandom_range(320, 4095)),
                  20'($urandom_range(0, 2000) - 1000), 20'($urandom_range(0, 2000) - 1000)};
         end else begin
            write_reg(REG_RADIAL, 64'd0);
            tv = {12'($urandom_range(320, 4095)), 12'($urandom_range(320, 4095)), 40'd0};
         end
         write_reg(REG_TANG_SIZE, tv);
         write_reg(REG_INTRINSICS, {4'd0, 20'(tv[63:52] * 128), 20'(tv[51:40] * 128),
                                    20'($urandom_range(256, 400000))});
      end
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($urandom_range(0, 2000000) - 1000000);
         default: return 32'($urandom_range(0, 40000000) - 20000000);
      endcase
   endfunction

   // Check each accepted response beat against the oldest prediction.
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         beats_out++;
         status_seen[rsp_chan.status]++;
         if (pending_pixels.size() == 0) begin
            $error("response beat with no point outstanding");
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_chan.status !== want.st) begin
               $error("status expected %0d actual %0d", want.st, rsp_chan.status);
               error_count++;
            end
            if (rsp_chan.pixel_u !== want.u) begin
               $error("pixel_u expected %0h actual %0h", want.u, rsp_chan.pixel_u);
               error_count++;
            end
            if (rsp_chan.pixel_v !== want.v) begin
               $error("pixel_v expected %0h actual %0h", want.v, rsp_chan.pixel_v);
               error_count++;
            end
         end
      end
   end

   // Predict on every accepted point beat.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         beats_in++;
         pending_pixels.insert(pending_pixels.size(),
                               project_point(req_chan.point_x, req_chan.point_y,
                                             req_chan.point_z));
      end
   end

   // Receiver: random stalls, with a forced long hold on request.
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_rsp) begin
         rsp_chan.ready <= 1'b0;
         repeat (150) @(posedge clock);
         hold_rsp = 1'b0;
      end else begin
         stall = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   // Main sequence.
   initial begin
      point_row_type rows [$];
      point_row_type r;
      pixel_type     tv;
      req_chan.valid   <= 1'b0;
      req_chan.point_x <= '0;
      req_chan.point_y <= '0;
      req_chan.point_z <= '0;
      csr_chan.valid   <= 1'b0;
      csr_chan.index   <= '0;
      csr_chan.data    <= '0;
      for (int i = 0; i < 8; i++) cam_reg[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset every rotation is zero, so depth is zero: behind camera.
      r = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1, ST_BEHIND};
      rows.insert(rows.size(), r);
      r = '{32'h0, 32'h0, 32'h0, 1, ST_BEHIND};
      rows.insert(rows.size(), r);
      foreach (rows[i]) begin
         // Typed rows must agree with the predictor that checks the block.
         if (rows[i].typed) begin
            tv = project_point(rows[i].px, rows[i].py, rows[i].pz);
            if (tv.st !== rows[i].st) begin
               $error("status expected %0d actual %0d", rows[i].st, tv.st);
               error_count++;
            end
         end
         send_point(rows[i].px, rows[i].py, rows[i].pz, 0);
      end
      stop_sending();
      drain_pipeline();

      // Undistorted camera: negative depth, zero depth, pixel origin, extremes.
      load_camera(0, 0);
      rows.delete();
      r = '{32'h0, 32'h0, 32'h8000_0000, 0, ST_OK};
      rows.insert(rows.size(), r);
      r = '{32'h0, 32'h0, cam_reg[REG_CENTER_Z][31:0], 0, ST_OK};
      rows.insert(rows.size(), r);
      r = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, ST_OK};
      rows.insert(rows.size(), r);
      r = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, ST_OK};
      rows.insert(rows.size(), r);
      r = '{32'h7FFF_FFFF, 32'h0, 32'h0010_0000, 0, ST_OK};
      rows.insert(rows.size(), r);
      r = '{32'h0, 32'h0, 32'h0100_0000, 0, ST_OK};
      rows.insert(rows.size(), r);
      r = '{32'hFFFF_FFFF, 32'h1, 32'h0000_0001, 0, ST_OK};
      rows.insert(rows.size(), r);
      r = '{32'h0002_0000, 32'hFFFE_0000, 32'h0020_0000, 0, ST_OK};
      rows.insert(rows.size(), r);
      foreach (rows[i]) begin
         r = rows[i];
         send_point(r.px, r.py, r.pz, 1);
      end
      stop_sending();
      drain_pipeline();

      // Zero image size rejects everything; zero focal passes the field check.
      write_reg(REG_TANG_SIZE, 64'd0);
      send_point(32'h0, 32'h0, 32'h0100_0000, 0);
      stop_sending();
      drain_pipeline();
      write_reg(REG_TANG_SIZE, {12'd640, 12'd640, 40'd0});
      write_reg(REG_INTRINSICS, 64'd0);
      send_point(32'h0, 32'h0, 32'h0100_0000, 0);
      // Principal point beyond image gives the outside-image code.
      stop_sending();
      drain_pipeline();
      write_reg(REG_INTRINSICS, {4'd0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF});
      tv = project_point(32'h0, 32'h0, 32'h7FFF_FFFF);
      if (tv.st == ST_IMAGE) send_point(32'h0, 32'h0, 32'h7FFF_FFFF, 0);
      stop_sending();
      drain_pipeline();

      // Random phases over several camera settings.
      for (int ph = 0; ph < 12; ph++) begin
         load_camera(ph % 6 == 5, ph % 2 == 1);
         for (int n = 0; n < 160; n++) begin
            if (ph == 3 && n == 20) hold_rsp = 1'b1;
            if (n == 80) begin
               // Sender pauses until every outstanding pixel has returned.
               stop_sending();
               @(posedge clock);
               while (pending_pixels.size() != 0) @(posedge clock);
            end
            if ($urandom_range(0, 3) == 0) begin
               send_point(rand_coord(), rand_coord(), rand_coord(), 1);
            end else begin
               send_point(32'($urandom_range(0, 600000) - 300000)
                             + cam_reg[REG_CENTER_XY][31:0],
                          32'($urandom_range(0, 600000) - 300000)
                             + cam_reg[REG_CENTER_XY][63:32],
                          32'($urandom_range(65536, 4000000))
                             + cam_reg[REG_CENTER_Z][31:0],
                          ph % 4 != 2);
            end
         end
         stop_sending();
         drain_pipeline();
      end
      stimulus_done = 1'b1;

      $display("Covered %0d points, %0d responses over 12 camera settings.",
               beats_in, beats_out);
      $display("Status counts: ok %0d, behind %0d, field %0d, image %0d.",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (error_count == 0 && pending_pixels.size() == 0) begin
         $display("PASS camera_point_projection_top");
      end else begin
         $display("FAIL camera_point_projection_top");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #20ms;
      $display("FAIL camera_point_projection_top");
      $finish;
   end
endmodule
